// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the rtl files; shot_feeder_sequencer includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sfs_pkg.sv =====
`timescale 1ns / 1ps

package sfs_pkg;

	// field widths
	localparam int unsigned TrigW   = 10;
	localparam int unsigned FeedW   = 12;
	localparam int unsigned FricW   = 13;
	localparam int unsigned MsW     = 16;
	localparam int unsigned StickW  = 11;
	localparam int unsigned TimeW   = 32;
	localparam int unsigned SpeedW  = 13;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned InDataW  = 56;
	localparam int unsigned OutDataW = 32;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_TRIGGER_LOW     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_TRIGGER_HIGH    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_FEED_SPEED      = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_FRICTION_SPEED  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_PUSH_HOLD_MS    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_RETRACT_WAIT_MS = 3'd5;

	// register reset values
	localparam logic [TrigW-1:0] TRIGGER_LOW_RST     = 10'd500;
	localparam logic [TrigW-1:0] TRIGGER_HIGH_RST    = 10'd660;
	localparam logic [FeedW-1:0] FEED_SPEED_RST      = 12'd300;
	localparam logic [FricW-1:0] FRICTION_SPEED_RST  = 13'd2000;
	localparam logic [MsW-1:0]   PUSH_HOLD_MS_RST    = 16'd100;
	localparam logic [MsW-1:0]   RETRACT_WAIT_MS_RST = 16'd100;

	// feed direction codes
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_POS  = 2'd1;
	localparam logic [1:0] DIR_NEG  = 2'd3;

	typedef enum logic [1:0] {
		PH_WAIT    = 2'd0,
		PH_PUSHING = 2'd1,
		PH_BACK    = 2'd2
	} phase_t;

endpackage

// ===== rtl/core/shot_feeder_sequencer.sv =====
`timescale 1ns / 1ps
// shot feeder sequencer: friction wheel level, feeder speed and pusher drive
// from one control tick per request
// input channel s_*: one control tick per request, shoot_mode in s_tuser,
//   sticks, projectile switch and millisecond time packed in s_tdata
// output channel m_*: exactly one result request per input request, in order
// config channel cfg_*: register index and data, always ready; write only
//   while no tick is in flight
// path: input accept loads the input register, then the result register loads
//   from it through the single combinational pass between the two registers;
//   throughput one request per cycle while the receiver keeps taking results
// the sequence state updates in the same cycle the result register loads
// when the receiver stalls, the result register holds and the input
//   register keeps at most one more request; s_tready drops once both are full
// reset clears the sequence to wait, drops both valids and loads the
//   register defaults; no clearing pass is needed
module shot_feeder_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave side
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sfs_pkg::InDataW-1:0]    s_tdata,  // burst_stick, single_stick,
	                                                 // projectile_present, time_ms, pad
	input  logic                           s_tuser,  // shoot_mode
	// master side
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sfs_pkg::OutDataW-1:0]   m_tdata,  // friction_level, feeder_speed,
	                                                 // pusher_extend, sequence_state, pad
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfs_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [sfs_pkg::CfgW-1:0]       cfg_data
);

	`include "assert_macros.svh"

	// configuration registers
	logic [sfs_pkg::TrigW-1:0] trig_low_q, trig_high_q;
	logic [sfs_pkg::FeedW-1:0] feed_speed_q;
	logic [sfs_pkg::FricW-1:0] friction_speed_q;
	logic [sfs_pkg::MsW-1:0]   push_hold_q, retract_wait_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_low_q       <= sfs_pkg::TRIGGER_LOW_RST;
			trig_high_q      <= sfs_pkg::TRIGGER_HIGH_RST;
			feed_speed_q     <= sfs_pkg::FEED_SPEED_RST;
			friction_speed_q <= sfs_pkg::FRICTION_SPEED_RST;
			push_hold_q      <= sfs_pkg::PUSH_HOLD_MS_RST;
			retract_wait_q   <= sfs_pkg::RETRACT_WAIT_MS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sfs_pkg::REG_TRIGGER_LOW:     trig_low_q       <= cfg_data[sfs_pkg::TrigW-1:0];
				sfs_pkg::REG_TRIGGER_HIGH:    trig_high_q      <= cfg_data[sfs_pkg::TrigW-1:0];
				sfs_pkg::REG_FEED_SPEED:      feed_speed_q     <= cfg_data[sfs_pkg::FeedW-1:0];
				sfs_pkg::REG_FRICTION_SPEED:  friction_speed_q <= cfg_data[sfs_pkg::FricW-1:0];
				sfs_pkg::REG_PUSH_HOLD_MS:    push_hold_q      <= cfg_data;
				sfs_pkg::REG_RETRACT_WAIT_MS: retract_wait_q   <= cfg_data;
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// input register
	logic                               s1_valid;
	logic                               s1_shoot;
	logic signed [sfs_pkg::StickW-1:0]  s1_burst, s1_single;
	logic                               s1_proj;
	logic [sfs_pkg::TimeW-1:0]          s1_time;
	logic                               advance;
	logic                               m_valid_q;

	// the stage moves when the result register is empty or being drained
	assign advance  = s1_valid && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_shoot  <= s_tuser;
			s1_burst  <= s_tdata[10:0];
			s1_single <= s_tdata[21:11];
			s1_proj   <= s_tdata[22];
			s1_time   <= s_tdata[54:23];
		end
	end

	// sequence state
	sfs_pkg::phase_t            phase_q, phase_d;
	logic [sfs_pkg::TimeW-1:0]  start_q, start_d;
	logic [1:0]                 dir_q, dir_d;
	logic                       supply_q, supply_d;
	logic                       prev_q, prev_d;
	logic                       pend_q, pend_d;

	// stick window: returns a direction code
	function automatic logic [1:0] window_dir(
		input logic signed [sfs_pkg::StickW-1:0] v,
		input logic [sfs_pkg::TrigW-1:0]         lo,
		input logic [sfs_pkg::TrigW-1:0]         hi
	);
		logic signed [sfs_pkg::StickW:0] vx, lo_s, hi_s;
		logic [1:0] r;
		vx   = {v[sfs_pkg::StickW-1], v};
		lo_s = signed'({2'b00, lo});
		hi_s = signed'({2'b00, hi});
		if (vx >= lo_s && vx <= hi_s) begin
			r = sfs_pkg::DIR_POS;
		end else if (vx <= -lo_s && vx >= -hi_s) begin
			r = sfs_pkg::DIR_NEG;
		end else begin
			r = sfs_pkg::DIR_NONE;
		end
		return r;
	endfunction

	logic [1:0]                        bd, sd;
	logic                              burst, single, rising, cmd, firing;
	logic [sfs_pkg::TimeW-1:0]         elapsed;
	logic signed [sfs_pkg::SpeedW-1:0] feed_pos, feed_val, feeder;
	logic [sfs_pkg::FricW-1:0]         friction;

	always_comb begin
		bd       = window_dir(s1_burst, trig_low_q, trig_high_q);
		sd       = window_dir(s1_single, trig_low_q, trig_high_q);
		burst    = bd != sfs_pkg::DIR_NONE;
		single   = sd != sfs_pkg::DIR_NONE;
		elapsed  = s1_time - start_q;
		feed_pos = signed'({1'b0, feed_speed_q});

		phase_d  = phase_q;
		start_d  = start_q;
		dir_d    = dir_q;
		supply_d = supply_q;
		prev_d   = prev_q;
		pend_d   = pend_q;
		friction = '0;
		feeder   = '0;
		rising   = 1'b0;
		cmd      = 1'b0;
		firing   = 1'b0;

		if (!s1_shoot) begin
			// leaving shoot mode clears everything
			phase_d  = sfs_pkg::PH_WAIT;
			start_d  = '0;
			dir_d    = sfs_pkg::DIR_NONE;
			supply_d = 1'b0;
			prev_d   = 1'b0;
			pend_d   = 1'b0;
		end else begin
			friction = friction_speed_q;
			if (burst) dir_d = bd;
			if (single) dir_d = sd;  // single stick wins
			rising = single && !prev_q;
			prev_d = single;
			if (rising) pend_d = 1'b1;
			cmd    = rising || burst;
			firing = cmd || pend_d;

			if (firing) begin
				supply_d = 1'b1;
			end else if (phase_q == sfs_pkg::PH_WAIT) begin
				supply_d = 1'b0;
			end
		end

		// feeder target for the updated direction
		if (dir_d == sfs_pkg::DIR_POS) begin
			feed_val = feed_pos;
		end else if (dir_d == sfs_pkg::DIR_NEG) begin
			feed_val = -feed_pos;
		end else begin
			feed_val = '0;
		end

		if (s1_shoot) begin
			if (!supply_d) begin
				phase_d = sfs_pkg::PH_WAIT;
				start_d = '0;
			end else begin
				unique case (phase_q)
					sfs_pkg::PH_WAIT: begin
						feeder = feed_val;
						if (s1_proj && firing) begin
							feeder  = '0;
							phase_d = sfs_pkg::PH_PUSHING;
							start_d = s1_time;
						end
					end
					sfs_pkg::PH_PUSHING: begin
						if (elapsed >= {16'd0, push_hold_q}) begin
							phase_d = sfs_pkg::PH_BACK;
							start_d = s1_time;
						end
					end
					sfs_pkg::PH_BACK: begin
						if (elapsed >= {16'd0, retract_wait_q}) begin
							phase_d = sfs_pkg::PH_WAIT;
							start_d = '0;
							feeder  = feed_val;
							if (!burst) pend_d = 1'b0;
							if (!cmd) supply_d = 1'b0;
						end
					end
					default: begin
						// unused encoding falls back to wait
						phase_d  = sfs_pkg::PH_WAIT;
						start_d  = '0;
						supply_d = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= sfs_pkg::PH_WAIT;
			start_q  <= '0;
			dir_q    <= sfs_pkg::DIR_NONE;
			supply_q <= 1'b0;
			prev_q   <= 1'b0;
			pend_q   <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			start_q  <= start_d;
			dir_q    <= dir_d;
			supply_q <= supply_d;
			prev_q   <= prev_d;
			pend_q   <= pend_d;
		end
	end

	// result register
	logic [sfs_pkg::OutDataW-1:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {3'b000, phase_d, phase_d == sfs_pkg::PH_PUSHING, feeder, friction};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// checks
	`ASSERT_NEXT(a_state_holds_on_stall, clk, arst_n, m_valid_q && !m_tready,
		$stable(phase_q) && $stable(start_q) && $stable(supply_q),
		"sequence state moved while the result was stalled")
	`ASSERT_NEXT(a_input_kept_on_stall, clk, arst_n, s1_valid && !advance,
		s1_valid && $stable(s1_time),
		"input register lost a request")
	`ASSERT_NEXT(a_clear_outside_shoot, clk, arst_n, advance && !s1_shoot,
		phase_q == sfs_pkg::PH_WAIT && !supply_q && !pend_q && dir_q == sfs_pkg::DIR_NONE,
		"state not cleared outside shoot mode")
	`ASSERT_SAME(a_push_needs_projectile, clk, arst_n,
		advance && phase_q == sfs_pkg::PH_WAIT && phase_d == sfs_pkg::PH_PUSHING,
		s1_proj && s1_shoot,
		"pusher started without a projectile")

endmodule

// ===== sim/tb_shot_feeder_sequencer.sv =====
`timescale 1ns / 1ps

module tb_shot_feeder_sequencer;

	// spare register slots, writes there must be dropped
	localparam logic [sfs_pkg::CfgIdxW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [sfs_pkg::CfgIdxW-1:0] REG_SPARE_B = 3'd7;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned N_ROWS      = 23;
	localparam int unsigned N_PHASES    = 10;
	localparam int unsigned PHASE_ITEMS = 130;

	// one control tick as it travels on the slave side
	typedef struct packed {
		logic        shoot;
		logic [10:0] burst;
		logic [10:0] single;
		logic        proj;
		logic [31:0] tm;
	} tick_t;

	// one drive result as it travels on the master side
	typedef struct packed {
		logic [12:0] fric;
		logic [12:0] feeder;
		logic        ext;
		logic [1:0]  st;
	} drive_t;

	typedef struct packed {
		tick_t  tick;
		logic   typed;
		drive_t want;
	} tick_row_t;

	localparam drive_t NO_WANT   = '0;
	localparam drive_t ALL_OFF   = '{13'd0, 13'd0, 1'b0, sfs_pkg::PH_WAIT};
	localparam drive_t SPIN_IDLE = '{13'd2000, 13'd0, 1'b0, sfs_pkg::PH_WAIT};

	// directed ticks, all under the reset register values
	localparam tick_row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
		// out of shoot mode with every field at an extreme
		'{'{1'b0, 11'sd1023, 11'h400, 1'b1, 32'hFFFF_FFFF}, 1'b1, ALL_OFF},
		// shoot mode, sticks centered: wheels spin, nothing else
		'{'{1'b1, 11'sd0, 11'sd0, 1'b0, 32'd0}, 1'b1, SPIN_IDLE},
		// burst at the low window edge feeds forward
		'{'{1'b1, 11'sd500, 11'sd0, 1'b0, 32'd10}, 1'b0, NO_WANT},
		// burst at the high edge with a projectile present starts the push
		'{'{1'b1, 11'sd660, 11'sd0, 1'b1, 32'd20}, 1'b0, NO_WANT},
		// just past the window, push continues
		'{'{1'b1, 11'sd661, 11'sd0, 1'b0, 32'd50}, 1'b0, NO_WANT},
		// hold time reached exactly
		'{'{1'b1, 11'h400, 11'sd0, 1'b0, 32'd120}, 1'b0, NO_WANT},
		'{'{1'b1, 11'sd0, 11'sd0, 1'b0, 32'd219}, 1'b0, NO_WANT},
		// retract wait reached, back to wait with no command
		'{'{1'b1, 11'sd0, 11'sd0, 1'b0, 32'd220}, 1'b0, NO_WANT},
		// single trigger, negative window, latches on the rising level
		'{'{1'b1, 11'sd0, -11'sd500, 1'b0, 32'd300}, 1'b0, NO_WANT},
		'{'{1'b1, 11'sd0, -11'sd660, 1'b1, 32'd301}, 1'b0, NO_WANT},
		'{'{1'b1, 11'sd0, 11'sd0, 1'b0, 32'd400}, 1'b0, NO_WANT},
		'{'{1'b1, 11'sd0, 11'sd0, 1'b0, 32'd401}, 1'b0, NO_WANT},
		'{'{1'b1, 11'sd0, 11'sd0, 1'b0, 32'd500}, 1'b0, NO_WANT},
		'{'{1'b1, 11'sd0, 11'sd0, 1'b0, 32'd501}, 1'b0, NO_WANT},
		// both sticks fire, the single stick sets the direction
		'{'{1'b1, 11'sd600, -11'sd600, 1'b0, 32'd600}, 1'b0, NO_WANT},
		// push starts just before the time counter wraps
		'{'{1'b1, 11'sd600, 11'sd1023, 1'b1, 32'hFFFF_FFC0}, 1'b0, NO_WANT},
		'{'{1'b1, 11'sd0, 11'sd0, 1'b0, 32'h0000_0023}, 1'b0, NO_WANT},
		'{'{1'b1, 11'sd0, 11'sd0, 1'b0, 32'h0000_0024}, 1'b0, NO_WANT},
		// leaving shoot mode mid-sequence clears it
		'{'{1'b0, 11'sd0, 11'sd0, 1'b1, 32'h0000_0050}, 1'b1, ALL_OFF},
		// both sticks outside the windows
		'{'{1'b1, -11'sd1023, 11'sd1023, 1'b1, 32'h7FFF_FFFF}, 1'b1, SPIN_IDLE},
		'{'{1'b1, 11'sd499, -11'sd661, 1'b0, 32'h8000_0000}, 1'b0, NO_WANT},
		'{'{1'b1, -11'sd500, 11'sd0, 1'b1, 32'h8000_0001}, 1'b0, NO_WANT},
		'{'{1'b0, 11'sd0, 11'sd0, 1'b0, 32'd0}, 1'b1, ALL_OFF}
	};

	// register settings of the fixed phases: low, high, feed, friction, hold, retract
	localparam int unsigned FIXED_CFG [0:4][0:5] = '{
		'{500, 660, 300, 2000, 20, 15},
		'{0, 1023, 4095, 8191, 0, 0},
		'{700, 300, 1234, 100, 5, 5},
		'{1023, 1023, 0, 0, 65535, 65535},
		'{0, 0, 2048, 4096, 1, 1}
	};

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         s_tvalid  = 1'b0;
	logic                         s_tready;
	logic [sfs_pkg::InDataW-1:0]  s_tdata   = '0;
	logic                         s_tuser   = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready  = 1'b0;
	logic [sfs_pkg::OutDataW-1:0] m_tdata;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [sfs_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [sfs_pkg::CfgW-1:0]     cfg_data  = '0;

	// typed expectation riding along with the tick on the bus
	logic   row_typed = 1'b0;
	drive_t row_want  = '0;

	// model copy of the registers
	logic [sfs_pkg::TrigW-1:0] c_lo   = sfs_pkg::TRIGGER_LOW_RST;
	logic [sfs_pkg::TrigW-1:0] c_hi   = sfs_pkg::TRIGGER_HIGH_RST;
	logic [sfs_pkg::FeedW-1:0] c_feed = sfs_pkg::FEED_SPEED_RST;
	logic [sfs_pkg::FricW-1:0] c_fric = sfs_pkg::FRICTION_SPEED_RST;
	logic [sfs_pkg::MsW-1:0]   c_hold = sfs_pkg::PUSH_HOLD_MS_RST;
	logic [sfs_pkg::MsW-1:0]   c_wait = sfs_pkg::RETRACT_WAIT_MS_RST;

	// model copy of the sequence state
	sfs_pkg::phase_t ph          = sfs_pkg::PH_WAIT;
	logic [31:0]     ph_start    = '0;
	logic [1:0]      fdir        = sfs_pkg::DIR_NONE;
	logic            supply      = 1'b0;
	logic            prev_single = 1'b0;
	logic            shot_latch  = 1'b0;

	drive_t      drive_q [$];
	int unsigned bad_count = 0;
	int unsigned cycles    = 0;

	// stimulus shaping shared by the two sides
	logic        calm    = 1'b0;
	int unsigned rx_hold = 0;
	int          cur_lo  = 500;
	int          cur_hi  = 660;

	shot_feeder_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// stick window: +1 or -1 direction code, none outside both windows
	function automatic logic [1:0] stick_dir(input logic [10:0] raw);
		int v;
		int lo;
		int hi;
		v  = int'($signed(raw));
		lo = int'(c_lo);
		hi = int'(c_hi);
		if (v >= lo && v <= hi)
			return sfs_pkg::DIR_POS;
		if (v <= -lo && v >= -hi)
			return sfs_pkg::DIR_NEG;
		return sfs_pkg::DIR_NONE;
	endfunction

	function automatic logic [12:0] feed_drive();
		if (fdir == sfs_pkg::DIR_POS)
			return {1'b0, c_feed};
		if (fdir == sfs_pkg::DIR_NEG)
			return 13'd0 - {1'b0, c_feed};
		return 13'd0;
	endfunction

	// one control tick through the sequencer, updates the model state
	function automatic drive_t advance_sequencer(input tick_t t);
		drive_t      r;
		logic [1:0]  bd;
		logic [1:0]  sd;
		logic        burst;
		logic        single;
		logic        rising;
		logic        cmd;
		logic        firing;
		logic [31:0] elapsed;
		r = '0;
		if (!t.shoot) begin
			ph          = sfs_pkg::PH_WAIT;
			ph_start    = '0;
			fdir        = sfs_pkg::DIR_NONE;
			supply      = 1'b0;
			prev_single = 1'b0;
			shot_latch  = 1'b0;
		end else begin
			bd       = stick_dir(t.burst);
			sd       = stick_dir(t.single);
			burst    = bd != sfs_pkg::DIR_NONE;
			single   = sd != sfs_pkg::DIR_NONE;
			r.fric   = c_fric;
			if (burst)
				fdir = bd;
			if (single)
				fdir = sd;
			rising      = single && !prev_single;
			prev_single = single;
			if (rising)
				shot_latch = 1'b1;
			cmd    = rising || burst;
			firing = cmd || shot_latch;
			if (firing)
				supply = 1'b1;
			else if (ph == sfs_pkg::PH_WAIT)
				supply = 1'b0;
			if (!supply) begin
				ph       = sfs_pkg::PH_WAIT;
				ph_start = '0;
			end else begin
				// wrapping millisecond difference
				elapsed = t.tm - ph_start;
				case (ph)
					sfs_pkg::PH_WAIT: begin
						r.feeder = feed_drive();
						if (t.proj && firing) begin
							r.feeder = '0;
							ph       = sfs_pkg::PH_PUSHING;
							ph_start = t.tm;
						end
					end
					sfs_pkg::PH_PUSHING: begin
						if (elapsed >= {16'd0, c_hold}) begin
							ph       = sfs_pkg::PH_BACK;
							ph_start = t.tm;
						end
					end
					sfs_pkg::PH_BACK: begin
						if (elapsed >= {16'd0, c_wait}) begin
							ph       = sfs_pkg::PH_WAIT;
							ph_start = '0;
							r.feeder = feed_drive();
							if (!burst)
								shot_latch = 1'b0;
							if (!cmd)
								supply = 1'b0;
						end
					end
					default: begin
						ph       = sfs_pkg::PH_WAIT;
						ph_start = '0;
						supply   = 1'b0;
					end
				endcase
			end
		end
		r.ext = ph == sfs_pkg::PH_PUSHING;
		r.st  = ph;
		return r;
	endfunction

	// bus watcher: model update on each accepted request, result compare
	always @(posedge clk) begin : bus_watch
		tick_t  t;
		drive_t got;
		drive_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.fric   = m_tdata[12:0];
				got.feeder = m_tdata[25:13];
				got.ext    = m_tdata[26];
				got.st     = m_tdata[28:27];
				if (drive_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("mismatch: result request with none pending, data %h", m_tdata);
				end else begin
					want = drive_q.pop_front();
					if (got.fric !== want.fric || got.feeder !== want.feeder ||
					    got.ext !== want.ext || got.st !== want.st) begin
						bad_count++;
						if (bad_count <= 10)
							$display({"mismatch at cycle %0d: friction %0d/%0d ",
							          "feeder %0d/%0d extend %b/%b state %0d/%0d ",
							          "(expected/actual)"},
							         cycles, want.fric, got.fric,
							         $signed(want.feeder), $signed(got.feeder),
							         want.ext, got.ext, want.st, got.st);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				t.shoot  = s_tuser;
				t.burst  = s_tdata[10:0];
				t.single = s_tdata[21:11];
				t.proj   = s_tdata[22];
				t.tm     = s_tdata[54:23];
				want     = advance_sequencer(t);
				if (row_typed)
					want = row_want;
				drive_q.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sfs_pkg::REG_TRIGGER_LOW:     c_lo   = cfg_data[sfs_pkg::TrigW-1:0];
					sfs_pkg::REG_TRIGGER_HIGH:    c_hi   = cfg_data[sfs_pkg::TrigW-1:0];
					sfs_pkg::REG_FEED_SPEED:      c_feed = cfg_data[sfs_pkg::FeedW-1:0];
					sfs_pkg::REG_FRICTION_SPEED:  c_fric = cfg_data[sfs_pkg::FricW-1:0];
					sfs_pkg::REG_PUSH_HOLD_MS:    c_hold = cfg_data[sfs_pkg::MsW-1:0];
					sfs_pkg::REG_RETRACT_WAIT_MS: c_wait = cfg_data[sfs_pkg::MsW-1:0];
					default: ;
				endcase
			end
		end
	end

	// receiver: random stall per result, long hold when asked
	initial begin : result_sink
		int unsigned k;
		forever begin
			if (rx_hold != 0) begin
				k       = rx_hold;
				rx_hold = 0;
				m_tready <= 1'b0;
				repeat (k) @(posedge clk);
			end else if (!calm) begin
				k = $urandom_range(0, 9);
				if (k != 0) begin
					m_tready <= 1'b0;
					repeat (k) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// one tick request, with a random gap ahead of it
	task automatic send_tick(input tick_t t, input logic typed, input drive_t want);
		int unsigned k;
		k = calm ? 0 : $urandom_range(0, 9);
		if (k != 0) begin
			s_tvalid <= 1'b0;
			repeat (k) @(posedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= {1'b0, t.tm, t.proj, t.single, t.burst};
		s_tuser   <= t.shoot;
		row_typed <= typed;
		row_want  <= want;
		do @(posedge clk); while (!s_tready);
	endtask

	// register write; bits above the register width carry noise
	task automatic cfg_write(input logic [sfs_pkg::CfgIdxW-1:0] idx,
	                         input logic [sfs_pkg::CfgW-1:0] val);
		logic [sfs_pkg::CfgW-1:0] keep;
		logic [sfs_pkg::CfgW-1:0] junk;
		logic [31:0]              noise;
		if (idx == sfs_pkg::REG_TRIGGER_LOW || idx == sfs_pkg::REG_TRIGGER_HIGH)
			keep = 16'h03FF;
		else if (idx == sfs_pkg::REG_FEED_SPEED)
			keep = 16'h0FFF;
		else if (idx == sfs_pkg::REG_FRICTION_SPEED)
			keep = 16'h1FFF;
		else if (idx == sfs_pkg::REG_PUSH_HOLD_MS || idx == sfs_pkg::REG_RETRACT_WAIT_MS)
			keep = 16'hFFFF;
		else
			keep = 16'h0000;
		noise = $urandom;
		junk  = noise[sfs_pkg::CfgW-1:0];
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= (val & keep) | (junk & ~keep);
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		do @(posedge clk); while (drive_q.size() != 0);
	endtask

	// stick value: often inside the windows, some at the edges, some near center, some noise
	function automatic logic [10:0] pick_stick();
		int          v;
		int unsigned m;
		m = $urandom_range(0, 99);
		if (m < 40 && cur_lo <= cur_hi) begin
			v = $urandom_range(cur_hi, cur_lo);
			if ($urandom_range(0, 1) == 1)
				v = -v;
		end else if (m < 55) begin
			case ($urandom_range(0, 5))
				0: v = cur_lo;
				1: v = cur_hi;
				2: v = -cur_lo;
				3: v = -cur_hi;
				4: v = cur_lo - 1;
				default: v = cur_hi + 1;
			endcase
		end else if (m < 80) begin
			v = int'($urandom_range(0, 20)) - 10;
		end else begin
			v = int'($urandom_range(0, 2047)) - 1024;
		end
		return v[10:0];
	endfunction

	initial begin : tick_source
		int unsigned cfgv [0:5];
		int unsigned span;
		tick_t       t;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_tick(DIRECTED_ROWS[i].tick, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

		for (int p = 0; p < N_PHASES; p++) begin
			if (p < 5) begin
				for (int j = 0; j < 6; j++)
					cfgv[j] = FIXED_CFG[p][j];
			end else begin
				cfgv[0] = $urandom_range(0, 1023);
				cfgv[1] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
				                                      : $urandom_range(1023, cfgv[0]);
				cfgv[2] = $urandom_range(0, 4095);
				cfgv[3] = $urandom_range(0, 8191);
				cfgv[4] = $urandom_range(0, 40);
				cfgv[5] = $urandom_range(0, 40);
			end

			// registers change only with the block empty
			s_tvalid <= 1'b0;
			drain();
			repeat (4) @(posedge clk);
			cfg_write(sfs_pkg::REG_TRIGGER_LOW, cfgv[0][sfs_pkg::CfgW-1:0]);
			cfg_write(sfs_pkg::REG_TRIGGER_HIGH, cfgv[1][sfs_pkg::CfgW-1:0]);
			cfg_write(sfs_pkg::REG_FEED_SPEED, cfgv[2][sfs_pkg::CfgW-1:0]);
			cfg_write(sfs_pkg::REG_FRICTION_SPEED, cfgv[3][sfs_pkg::CfgW-1:0]);
			cfg_write(sfs_pkg::REG_PUSH_HOLD_MS, cfgv[4][sfs_pkg::CfgW-1:0]);
			cfg_write(sfs_pkg::REG_RETRACT_WAIT_MS, cfgv[5][sfs_pkg::CfgW-1:0]);
			cfg_write(REG_SPARE_A, '0);
			cfg_write(REG_SPARE_B, '0);
			cfg_valid <= 1'b0;
			cur_lo = cfgv[0];
			cur_hi = cfgv[1];
			span   = (cfgv[4] > cfgv[5]) ? cfgv[4] : cfgv[5];

			t.tm     = $urandom;
			t.burst  = pick_stick();
			t.single = pick_stick();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				calm = (n >= 60 && n < 90);
				// receiver holds off while ticks keep coming, filling the block
				if (p == 1 && n == 40)
					rx_hold = 80;
				// sender waits for every result before going on
				if (p == 3 && n == 100) begin
					s_tvalid <= 1'b0;
					drain();
				end
				if ($urandom_range(0, 2) == 0)
					t.burst = pick_stick();
				if ($urandom_range(0, 2) == 0)
					t.single = pick_stick();
				t.shoot = $urandom_range(0, 39) != 0;
				t.proj  = $urandom_range(0, 1) == 1;
				if ($urandom_range(0, 19) == 0)
					t.tm = $urandom;
				else
					t.tm = t.tm + $urandom_range(0, span + span / 2 + 3);
				send_tick(t, 1'b0, NO_WANT);
			end
			calm = 1'b0;
		end

		s_tvalid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);
		if (bad_count == 0 && drive_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
